// ----- rtl/tilt_pkg.sv -----
`timescale 1ns / 1ps
package tilt_pkg;

	// field widths
	localparam int IN_W = 16;
	localparam int AXIS_W = IN_W + 1;
	localparam int SQR_W = 2 * AXIS_W - 1;
	localparam int SQ_W = SQR_W + 1;
	localparam int ANGLE_W = 16;

	// square root of sq * 2^30, digit by digit
	localparam int RAD_SHIFT = 30;
	localparam int RAD_W = SQ_W + RAD_SHIFT;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 2;

	// cordic datapath
	localparam int NUM_SHIFT = 15;
	localparam int XW = 36;
	localparam int ZW = 26;
	localparam int TAB_W = 22;
	localparam int TABLE_LEN = 24;
	localparam int INT_FRAC = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// output scaling
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int ROUND_SHIFT = INT_FRAC - ANGLE_FRAC_BITS;
	localparam int ROUND_HALF = 1 << (ROUND_SHIFT - 1);
	localparam int ANGLE_LIM = 90 << ANGLE_FRAC_BITS;
	localparam int OUT_MAX = (ANGLE_LIM > 32767) ? 32767 : ANGLE_LIM;
	localparam int OUT_MIN = (ANGLE_LIM > 32768) ? -32768 : -ANGLE_LIM;

	// queue between front and back, power of two depth
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
	localparam int FRONT_STAGES = 3;

	// register map
	localparam int CFG_ADDR_W = 4;
	localparam logic [1:0] REG_X_OFF = 2'd0;
	localparam logic [1:0] REG_Y_OFF = 2'd1;
	localparam logic [1:0] REG_Z_OFF = 2'd2;

	typedef struct packed {
		logic signed [AXIS_W-1:0] num_x;
		logic signed [AXIS_W-1:0] num_y;
		logic signed [AXIS_W-1:0] num_z;
		logic [SQ_W-1:0] sq_yz;
		logic [SQ_W-1:0] sq_xz;
		logic [SQ_W-1:0] sq_xy;
	} tilt_item_t;

	typedef struct packed {
		logic empty;
		logic [LVL_W-1:0] level;
	} tilt_fifo_stat_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic [TAB_W-1:0] atan_tab(input int i);
		logic [TAB_W-1:0] v;
		unique case (i)
			0: v = 22'd2949120;
			1: v = 22'd1740967;
			2: v = 22'd919879;
			3: v = 22'd466945;
			4: v = 22'd234379;
			5: v = 22'd117304;
			6: v = 22'd58666;
			7: v = 22'd29335;
			8: v = 22'd14668;
			9: v = 22'd7334;
			10: v = 22'd3667;
			11: v = 22'd1833;
			12: v = 22'd917;
			13: v = 22'd458;
			14: v = 22'd229;
			15: v = 22'd115;
			16: v = 22'd57;
			17: v = 22'd29;
			18: v = 22'd14;
			19: v = 22'd7;
			20: v = 22'd4;
			21: v = 22'd2;
			22: v = 22'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/tilt_front.sv -----
`timescale 1ns / 1ps
module tilt_front (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic signed [tilt_pkg::IN_W-1:0] accel_x,
	input logic signed [tilt_pkg::IN_W-1:0] accel_y,
	input logic signed [tilt_pkg::IN_W-1:0] accel_z,
	input logic signed [tilt_pkg::IN_W-1:0] x_off,
	input logic signed [tilt_pkg::IN_W-1:0] y_off,
	input logic signed [tilt_pkg::IN_W-1:0] z_off,
	output logic item_vld,
	output tilt_pkg::tilt_item_t item
);
	import tilt_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	logic signed [AXIS_W-1:0] ax_s1, ay_s1, az_s1;
	logic signed [AXIS_W-1:0] ax_s2, ay_s2, az_s2;
	logic [SQR_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	tilt_item_t item_s3;
	logic signed [2*AXIS_W-1:0] px, py, pz;

	assign px = ax_s1 * ax_s1;
	assign py = ay_s1 * ay_s1;
	assign pz = az_s1 * az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// offset correction, squares, then the three magnitude sums
	always_ff @(posedge clk) begin
		ax_s1 <= {accel_x[IN_W-1], accel_x} + {x_off[IN_W-1], x_off};
		ay_s1 <= {accel_y[IN_W-1], accel_y} + {y_off[IN_W-1], y_off};
		az_s1 <= {accel_z[IN_W-1], accel_z} + {z_off[IN_W-1], z_off};
		ax_s2 <= ax_s1;
		ay_s2 <= ay_s1;
		az_s2 <= az_s1;
		sqx_s2 <= SQR_W'(px);
		sqy_s2 <= SQR_W'(py);
		sqz_s2 <= SQR_W'(pz);
		item_s3.num_x <= ax_s2;
		item_s3.num_y <= ay_s2;
		item_s3.num_z <= az_s2;
		item_s3.sq_yz <= {1'b0, sqy_s2} + {1'b0, sqz_s2};
		item_s3.sq_xz <= {1'b0, sqx_s2} + {1'b0, sqz_s2};
		item_s3.sq_xy <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	assign item_vld = vld_s3;
	assign item = item_s3;

endmodule

// ----- rtl/tilt_fifo.sv -----
`timescale 1ns / 1ps
module tilt_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tilt_pkg::tilt_item_t din,
	input logic pop,
	output tilt_pkg::tilt_item_t dout,
	output tilt_pkg::tilt_fifo_stat_t stat
);
	import tilt_pkg::*;

	tilt_item_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic do_pop;

	assign do_pop = pop && (level_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	assign dout = mem_q[rd_ptr_q];
	assign stat.empty = (level_q == '0);
	assign stat.level = level_q;

endmodule

// ----- rtl/tilt_lane.sv -----
`timescale 1ns / 1ps
module tilt_lane #(
	parameter int CORDIC_STAGES = tilt_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic signed [tilt_pkg::AXIS_W-1:0] num,
	input logic [tilt_pkg::SQ_W-1:0] sq,
	output logic signed [tilt_pkg::ANGLE_W-1:0] angle
);
	import tilt_pkg::*;

	localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam logic signed [ZW-1:0] RMAX = ZW'(OUT_MAX);
	localparam logic signed [ZW-1:0] RMIN = ZW'(OUT_MIN);

	logic [SQ_W-1:0] sq_s [0:ROOT_W];
	logic [REM_W-1:0] rem_s [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	logic signed [AXIS_W-1:0] num_s [0:ROOT_W];

	logic signed [XW-1:0] x_c [0:NSTG];
	logic signed [XW-1:0] y_c [0:NSTG];
	logic signed [ZW-1:0] z_c [0:NSTG];
	logic mzero_c [0:NSTG];
	logic pos_c [0:NSTG];
	logic neg_c [0:NSTG];

	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [ZW-1:0] rnd;
	logic signed [ZW-1:0] sel;

	always_ff @(posedge clk) begin
		sq_s[0] <= sq;
		rem_s[0] <= '0;
		root_s[0] <= '0;
		num_s[0] <= num;
	end

	// one root bit per stage
	for (genvar S = 0; S < ROOT_W; S++) begin : g_sqrt
		localparam int P = ROOT_W - 1 - S;
		logic [RAD_W-1:0] rad;
		logic [REM_W+1:0] cand;
		logic [REM_W+1:0] trial;

		assign rad = {sq_s[S], {RAD_SHIFT{1'b0}}};
		assign cand = {rem_s[S], rad[2*P+1 -: 2]};
		assign trial = {{(REM_W - ROOT_W){1'b0}}, root_s[S], 2'b01};

		always_ff @(posedge clk) begin
			if (cand >= trial) begin
				rem_s[S+1] <= REM_W'(cand - trial);
				root_s[S+1] <= {root_s[S][ROOT_W-2:0], 1'b1};
			end else begin
				rem_s[S+1] <= REM_W'(cand);
				root_s[S+1] <= {root_s[S][ROOT_W-2:0], 1'b0};
			end
			sq_s[S+1] <= sq_s[S];
			num_s[S+1] <= num_s[S];
		end
	end

	always_ff @(posedge clk) begin
		x_c[0] <= {{(XW - ROOT_W){1'b0}}, root_s[ROOT_W]};
		y_c[0] <= {{(XW - AXIS_W - NUM_SHIFT){num_s[ROOT_W][AXIS_W-1]}},
			num_s[ROOT_W], {NUM_SHIFT{1'b0}}};
		z_c[0] <= '0;
		mzero_c[0] <= (root_s[ROOT_W] == '0);
		pos_c[0] <= (num_s[ROOT_W] != '0) && !num_s[ROOT_W][AXIS_W-1];
		neg_c[0] <= num_s[ROOT_W][AXIS_W-1];
	end

	// vectoring rotations, drive y towards zero
	for (genvar I = 0; I < NSTG; I++) begin : g_cordic
		localparam logic signed [ZW-1:0] T = ZW'(atan_tab(I));
		logic signed [XW-1:0] dx, dy;

		assign dx = y_c[I] >>> I;
		assign dy = x_c[I] >>> I;

		always_ff @(posedge clk) begin
			if (!y_c[I][XW-1]) begin
				x_c[I+1] <= x_c[I] + dx;
				y_c[I+1] <= y_c[I] - dy;
				z_c[I+1] <= z_c[I] + T;
			end else begin
				x_c[I+1] <= x_c[I] - dx;
				y_c[I+1] <= y_c[I] + dy;
				z_c[I+1] <= z_c[I] - T;
			end
			mzero_c[I+1] <= mzero_c[I];
			pos_c[I+1] <= pos_c[I];
			neg_c[I+1] <= neg_c[I];
		end
	end

	assign rnd = (z_c[NSTG] + ZW'(ROUND_HALF)) >>> ROUND_SHIFT;

	always_comb begin
		priority if (mzero_c[NSTG]) begin
			sel = pos_c[NSTG] ? RMAX : (neg_c[NSTG] ? RMIN : '0);
		end else if (rnd > RMAX) begin
			sel = RMAX;
		end else if (rnd < RMIN) begin
			sel = RMIN;
		end else begin
			sel = rnd;
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= ANGLE_W'(sel);
	end

	assign angle = angle_q;

endmodule

// ----- rtl/accel_tilt_angles_top.sv -----
// accelerometer tilt angles: pitch, roll and z tilt in fixed-point degrees
// each accepted request passes the front, the queue and the three lanes before done marks its results
// throughput: one request per clock while busy is low; the root and cordic lanes are fully pipelined
// the receiver cannot stall, so busy only rises if the queue level ever reaches FIFO_DEPTH - FRONT_STAGES
// arst_n clears the offsets, the queue and all valid flags; datapath registers are not reset
`timescale 1ns / 1ps
module accel_tilt_angles_top #(
	parameter int CORDIC_STAGES = tilt_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	// apb configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tilt_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// request side
	input logic start,
	output logic busy,
	input logic signed [tilt_pkg::IN_W-1:0] accel_x,
	input logic signed [tilt_pkg::IN_W-1:0] accel_y,
	input logic signed [tilt_pkg::IN_W-1:0] accel_z,
	// result side
	output logic done,
	output logic signed [tilt_pkg::ANGLE_W-1:0] pitch,
	output logic signed [tilt_pkg::ANGLE_W-1:0] roll,
	output logic signed [tilt_pkg::ANGLE_W-1:0] tilt_z
);
	import tilt_pkg::*;

	localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	// input register, root stages, cordic load, rotations, rounding register
	localparam int LANE_LAT = ROOT_W + NSTG + 3;

	logic signed [IN_W-1:0] x_off_q, y_off_q, z_off_q;
	logic cfg_wr;
	logic accept;
	logic item_vld;
	tilt_item_t item;
	tilt_item_t head;
	tilt_fifo_stat_t fifo_stat;
	logic pop;
	logic [LANE_LAT-1:0] vld_q;

	// register file, writes complete in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= '0;
			y_off_q <= '0;
			z_off_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_X_OFF: x_off_q <= pwdata[IN_W-1:0];
				REG_Y_OFF: y_off_q <= pwdata[IN_W-1:0];
				REG_Z_OFF: z_off_q <= pwdata[IN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_X_OFF: prdata = {{(32 - IN_W){1'b0}}, x_off_q};
			REG_Y_OFF: prdata = {{(32 - IN_W){1'b0}}, y_off_q};
			REG_Z_OFF: prdata = {{(32 - IN_W){1'b0}}, z_off_q};
			default: prdata = '0;
		endcase
	end

	// front: offsets, squares and magnitude sums, three stages
	// busy keeps room in the queue for everything the front still holds
	assign busy = (fifo_stat.level >= LVL_W'(FIFO_DEPTH - FRONT_STAGES));
	assign accept = start && !busy;

	tilt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.x_off(x_off_q),
		.y_off(y_off_q),
		.z_off(z_off_q),
		.item_vld(item_vld),
		.item(item)
	);

	tilt_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(item_vld),
		.din(item),
		.pop(pop),
		.dout(head),
		.stat(fifo_stat)
	);

	// back: the lanes never stall, so the queue drains whenever it holds a request
	assign pop = !fifo_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LANE_LAT-2:0], pop};
		end
	end

	tilt_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk),
		.num(head.num_x),
		.sq(head.sq_yz),
		.angle(pitch)
	);

	tilt_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk),
		.num(head.num_y),
		.sq(head.sq_xz),
		.angle(roll)
	);

	tilt_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_tilt_z (
		.clk(clk),
		.num(head.num_z),
		.sq(head.sq_xy),
		.angle(tilt_z)
	);

	assign done = vld_q[LANE_LAT-1];

`ifndef SYNTHESIS
	// back drains every cycle, so the queue never holds more than one request
	a_queue_shallow: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_stat.level == '0) || (fifo_stat.level == LVL_W'(1)))
		else $error("tilt queue deeper than one");

	// every popped request leaves the lanes exactly once, a fixed time later
	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(pop, LANE_LAT))
		else $error("tilt result strobe out of step with queue");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch <= OUT_MAX && pitch >= OUT_MIN && roll <= OUT_MAX
			&& roll >= OUT_MIN && tilt_z <= OUT_MAX && tilt_z >= OUT_MIN))
		else $error("tilt angle beyond ninety degrees");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import tilt_pkg::*;

	// run shape
	localparam int PHASES = 8;
	localparam int PER_PHASE = 210;
	localparam int DRAIN_CYCLES = 70;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic signed [IN_W-1:0] ax;
		logic signed [IN_W-1:0] ay;
		logic signed [IN_W-1:0] az;
		bit typed;
		logic signed [ANGLE_W-1:0] p;
		logic signed [ANGLE_W-1:0] r;
		logic signed [ANGLE_W-1:0] t;
	} vec_row_t;

	typedef struct {
		logic signed [ANGLE_W-1:0] p;
		logic signed [ANGLE_W-1:0] r;
		logic signed [ANGLE_W-1:0] t;
	} angles_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic signed [IN_W-1:0] accel_x, accel_y, accel_z;
	logic done;
	logic signed [ANGLE_W-1:0] pitch, roll, tilt_z;

	// our copy of the offset registers
	logic signed [IN_W-1:0] offs [3];

	// angles still owed by the block, oldest first
	angles_t owed_angles[$];
	// typed answers for directed rows, handed to the monitor in request order
	angles_t typed_q[$];
	bit typed_flag_q[$];
	int n_errors;
	int idle_cycles;

	accel_tilt_angles_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.done(done),
		.pitch(pitch),
		.roll(roll),
		.tilt_z(tilt_z)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// integer square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// atan(2^-i) in degrees with 16 fraction bits
	function automatic longint atan_step(input int i);
		longint steps [TABLE_LEN] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
			4, 2, 1, 0};
		return steps[i];
	endfunction

	// atan2(num, sqrt(a^2 + b^2)) in output degrees
	function automatic logic signed [ANGLE_W-1:0] tilt_angle(input longint num,
			input longint a, input longint b);
		longint unsigned sq;
		longint xm, yn, acc, dx, dy, res;
		longint lim;
		lim = longint'(90) << ANGLE_FRAC_BITS;
		sq = longint'(a * a) + longint'(b * b);
		xm = longint'(int_sqrt(sq << 30));
		yn = num * 32768;
		acc = 0;
		if (xm == 0) begin
			// flat magnitude: straight up, straight down, or nothing
			res = (num > 0) ? lim : (num < 0) ? -lim : 0;
		end else begin
			for (int i = 0; i < CORDIC_STAGES_DEF && i < TABLE_LEN; i++) begin
				dx = yn >>> i;
				dy = xm >>> i;
				if (yn >= 0) begin
					xm = xm + dx;
					yn = yn - dy;
					acc = acc + atan_step(i);
				end else begin
					xm = xm - dx;
					yn = yn + dy;
					acc = acc - atan_step(i);
				end
			end
			res = (acc + (longint'(1) << (INT_FRAC - ANGLE_FRAC_BITS - 1)))
				>>> (INT_FRAC - ANGLE_FRAC_BITS);
			if (res > lim) res = lim;
			if (res < -lim) res = -lim;
		end
		if (res > 32767) res = 32767;
		if (res < -32768) res = -32768;
		return res[ANGLE_W-1:0];
	endfunction

	function automatic angles_t predict_angles(input logic signed [IN_W-1:0] ax,
			input logic signed [IN_W-1:0] ay, input logic signed [IN_W-1:0] az);
		longint cx, cy, cz;
		angles_t a;
		cx = longint'(ax) + longint'(offs[0]);
		cy = longint'(ay) + longint'(offs[1]);
		cz = longint'(az) + longint'(offs[2]);
		a.p = tilt_angle(cx, cy, cz);
		a.r = tilt_angle(cy, cx, cz);
		a.t = tilt_angle(cz, cx, cy);
		return a;
	endfunction

	// one axis of random content, biased towards the interesting corners
	function automatic logic signed [IN_W-1:0] pick_axis(input logic signed [IN_W-1:0] off);
		int mode;
		longint v;
		mode = $urandom_range(0, 9);
		case (mode)
			5: begin
				v = $urandom_range(0, 1) ? 32767 : -32768;
			end
			6: begin
				v = longint'($urandom_range(0, 6)) - 3;
			end
			7: begin
				// lands the corrected axis on or near zero
				v = -longint'(off) + longint'($urandom_range(0, 2)) - 1;
			end
			8, 9: begin
				v = longint'($urandom_range(0, 8192)) - 4096;
			end
			default: begin
				v = longint'($signed(16'($urandom)));
			end
		endcase
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[IN_W-1:0];
	endfunction

	// apb write, setup then access
	task automatic cfg_write(input logic [1:0] idx, input logic signed [IN_W-1:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = CFG_ADDR_W'(idx) << 2;
		pwdata = {{16{val[IN_W-1]}}, val};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		offs[idx] = val;
	endtask

	task automatic wait_drained();
		while (owed_angles.size() != 0)
			@(posedge clk);
	endtask

	// present one request and hold it until taken, then idle a random while unless it is a quiet run
	task automatic send_sample(input logic signed [IN_W-1:0] ax,
			input logic signed [IN_W-1:0] ay, input logic signed [IN_W-1:0] az,
			input bit quiet_run);
		int gap;
		@(negedge clk);
		start = 1'b1;
		accel_x = ax;
		accel_y = ay;
		accel_z = az;
		do
			@(posedge clk);
		while (busy);
		gap = quiet_run ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// monitor: book each accepted request and check each result
	always @(posedge clk) begin
		angles_t exp_a;
		bit typed;
		if (arst_n) begin
			if (start && !busy) begin
				exp_a = predict_angles(accel_x, accel_y, accel_z);
				typed = (typed_flag_q.size() != 0) ? typed_flag_q.pop_front() : 1'b0;
				if (typed) exp_a = typed_q.pop_front();
				owed_angles.push_back(exp_a);
			end
			if (done) begin
				if (owed_angles.size() == 0) begin
					$display("%0t: unexpected result pitch %0d roll %0d tilt_z %0d",
						$time, pitch, roll, tilt_z);
					n_errors++;
				end else begin
					exp_a = owed_angles.pop_front();
					if (pitch !== exp_a.p) begin
						$display("%0t: pitch expected %0d actual %0d", $time, exp_a.p, pitch);
						n_errors++;
					end
					if (roll !== exp_a.r) begin
						$display("%0t: roll expected %0d actual %0d", $time, exp_a.r, roll);
						n_errors++;
					end
					if (tilt_z !== exp_a.t) begin
						$display("%0t: tilt_z expected %0d actual %0d", $time, exp_a.t, tilt_z);
						n_errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no traffic either way
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		vec_row_t rows [$];
		logic signed [IN_W-1:0] o0, o1, o2;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		n_errors = 0;
		idle_cycles = 0;
		offs[0] = '0;
		offs[1] = '0;
		offs[2] = '0;

		// directed rows: zero sample, lone axes, extremes, mixed signs
		rows = '{
			'{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 16'sd0},
			'{16'sd1, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
			'{-16'sd1, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
			'{16'sd0, 16'sd1, 16'sd0, 1'b0, 0, 0, 0},
			'{16'sd0, -16'sd1, 16'sd0, 1'b0, 0, 0, 0},
			'{16'sd0, 16'sd0, 16'sd1, 1'b0, 0, 0, 0},
			'{16'sd0, 16'sd0, -16'sd1, 1'b0, 0, 0, 0},
			'{16'sd32767, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
			'{-16'sd32768, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
			'{16'sd0, 16'sd0, 16'sd32767, 1'b0, 0, 0, 0},
			'{16'sd0, 16'sd0, -16'sd32768, 1'b0, 0, 0, 0},
			'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 0, 0, 0},
			'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 0, 0, 0},
			'{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 0, 0, 0},
			'{-16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 0, 0, 0},
			'{16'sd16384, 16'sd0, 16'sd16384, 1'b0, 0, 0, 0},
			'{16'sd100, 16'sd200, -16'sd300, 1'b0, 0, 0, 0},
			'{-16'sd4096, 16'sd4096, 16'sd16384, 1'b0, 0, 0, 0},
			'{16'sd1, 16'sd1, 16'sd1, 1'b0, 0, 0, 0},
			'{-16'sd21846, -16'sd21846, 16'sd21845, 1'b0, 0, 0, 0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			typed_flag_q.push_back(rows[i].typed);
			if (rows[i].typed) typed_q.push_back('{rows[i].p, rows[i].r, rows[i].t});
			send_sample(rows[i].ax, rows[i].ay, rows[i].az, 1'b0);
		end

		// random phases; offsets change only once the pipe has drained
		for (int ph = 0; ph < PHASES; ph++) begin
			@(negedge clk);
			start = 1'b0;
			wait_drained();
			case (ph)
				0: begin o0 = 16'sh7fff; o1 = 16'sh7fff; o2 = 16'sh7fff; end
				1: begin o0 = 16'sh8000; o1 = 16'sh8000; o2 = 16'sh8000; end
				2: begin o0 = 16'sh7fff; o1 = 16'sh8000; o2 = 16'sd0; end
				3: begin o0 = 16'sd0; o1 = 16'sd0; o2 = 16'sd0; end
				default: begin
					o0 = 16'($urandom);
					o1 = 16'($urandom);
					o2 = 16'($urandom);
				end
			endcase
			cfg_write(REG_X_OFF, o0);
			cfg_write(REG_Y_OFF, o1);
			cfg_write(REG_Z_OFF, o2);
			for (int k = 0; k < PER_PHASE; k++) begin
				// the first ten of every fifty requests run back to back with no gaps
				send_sample(pick_axis(offs[0]), pick_axis(offs[1]), pick_axis(offs[2]),
					(k % 50) < 10);
			end
		end

		@(negedge clk);
		start = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/tilt_pkg.sv
rtl/tilt_front.sv
rtl/tilt_fifo.sv
rtl/tilt_lane.sv
rtl/accel_tilt_angles_top.sv
tb/sv/tb_top.sv
